// File: rtl/pds_pkg.sv
// Shared types, character codes and helper functions for the percent decoder.
package pds_pkg;

    localparam logic [7:0] CHAR_PCT = 8'h25;
    localparam logic [7:0] CHAR_QMK = 8'h3F;

    localparam int unsigned RES_MAX = 3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HEX  = 2'd2;
    localparam logic [1:0] PH_BAD  = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } pds_item_t;

    typedef struct packed {
        logic [RES_MAX-1:0][7:0] data;
        logic [1:0]              cnt;
        logic                    text_end;
    } pds_group_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // bit 4: valid hex digit, bits 3:0: its value (upper-case digits only)
    function automatic logic [4:0] hex_dec(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/pds_in_reg.sv
// Input register stage of the percent decoder.
module pds_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // in_byte[7:0]
    input  logic              s_tlast,   // is_last
    input  logic              load,
    output logic              item_vld,
    output pds_pkg::pds_item_t item
);
    import pds_pkg::*;

    logic      vld_reg;
    pds_item_t item_reg;

    assign s_tready = !vld_reg || load;
    assign item_vld = vld_reg;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.data <= s_tdata;
            item_reg.last <= s_tlast;
        end
    end

endmodule

// File: rtl/pds_decode.sv
// Escape state and decode logic: turns one item into a group of up to three results.
module pds_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  pds_pkg::pds_item_t item,
    input  logic               load,
    output pds_pkg::pds_group_t grp
);
    import pds_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] up;
    logic [4:0] hv;
    logic [4:0] hh;

    always_comb
    begin
        up = to_upper(item.data);
        hv = hex_dec(up);
        hh = hex_dec(held_reg);
        phase_next   = phase_reg;
        held_next    = held_reg;
        grp.data[0]  = item.data;
        grp.data[1]  = held_reg;
        grp.data[2]  = item.data;
        grp.cnt      = 2'd0;
        grp.text_end = item.last;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.data == CHAR_PCT)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    grp.cnt = 2'd1;
                end
            end
            PH_PCT:
            begin
                held_next  = up;
                phase_next = hv[4] ? PH_HEX : PH_BAD;
            end
            PH_HEX:
            begin
                grp.data[0] = hv[4] ? {hh[3:0], hv[3:0]} : CHAR_QMK;
                grp.cnt     = 2'd1;
                phase_next  = PH_IDLE;
                held_next   = 8'h00;
            end
            PH_BAD:
            begin
                grp.data[0] = CHAR_PCT;
                phase_next  = PH_IDLE;
                held_next   = 8'h00;
                if (held_reg == CHAR_PCT)
                begin
                    // held percent opens a new escape with this item
                    held_next  = up;
                    phase_next = hv[4] ? PH_HEX : PH_BAD;
                    grp.cnt    = 2'd1;
                end
                else if (item.data == CHAR_PCT)
                begin
                    phase_next = PH_PCT;
                    grp.cnt    = 2'd2;
                end
                else
                begin
                    grp.cnt = 2'd3;
                end
            end
        endcase
        if (item.last)
        begin
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (load)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (load && item.last) |=> (phase_reg == PH_IDLE && held_reg == 8'h00))
        else $error("escape state not cleared after last item");

    a_pct_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (load && phase_reg == PH_PCT) |-> (grp.cnt == 2'd0))
        else $error("results produced while opening an escape");

endmodule

// File: rtl/pds_out_buf.sv
// Result register: holds one group and hands its results out one item at a time.
module pds_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  pds_pkg::pds_group_t grp,
    input  logic                load,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // out_byte[7:0]
    output logic                m_tlast,   // run_last
    output logic                m_tuser    // text_end
);
    import pds_pkg::*;

    logic [1:0]              rem_reg;
    logic [RES_MAX-1:0][7:0] res_reg;
    logic                    end_reg;
    logic                    take;

    assign take     = m_tvalid && m_tready;
    assign can_load = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_tready);
    assign m_tvalid = rem_reg != 2'd0;
    assign m_tdata  = res_reg[0];
    assign m_tlast  = rem_reg == 2'd1;
    assign m_tuser  = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
        end
        else if (load)
        begin
            rem_reg <= grp.cnt;
        end
        else if (take)
        begin
            rem_reg <= rem_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= grp.data;
            end_reg <= grp.text_end;
        end
        else if (take)
        begin
            // advance the remaining results
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (take && rem_reg > 2'd1) |=> (m_tdata == $past(res_reg[1])))
        else $error("result order broken on advance");

    a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (load && grp.cnt != 2'd0) |=> (rem_reg == $past(grp.cnt) && m_tvalid))
        else $error("group count not taken on load");

endmodule

// File: rtl/percent_decode_stream_unit.sv
// Top level of the streaming URL percent decoder.
//
// Input channel s_*: one nonzero text byte per item in s_tdata, with s_tlast on
// the final byte of a string. Output channel m_*: decoded bytes in m_tdata,
// m_tlast on the last result caused by one input item, m_tuser on every result
// caused by the final input byte of a string.
// A '%' and two hex digits give one byte; a '%', a hex digit and a non-hex byte
// give '?'; a '%' and a non-hex byte give '%', then that byte upper-cased and
// taken again as fresh input. An escape cut short by the end of a string is
// dropped. An input item causes zero to three results.
// An accepted input item is loaded into the input register at the accepting edge;
// its results are loaded from there into the result register once can_load is high.
// Throughput: one item per cycle while each item causes at most one result and
// m_tready is high; an item with two or three results holds the input while the
// result register drains them, one result per cycle while m_tready is high.
// Reset: clears the escape state, the input register and the result register;
// both channels are idle afterwards.
// Stall: when m_tready is low the current result holds, the next group waits
// in the input register and s_tready drops once that register is full.
module percent_decode_stream_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // text_end
);
    import pds_pkg::*;

    pds_item_t  item;
    pds_group_t grp;
    logic       item_vld;
    logic       can_load;
    logic       load;

    assign load = item_vld && can_load;

    pds_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .load     (load),
        .item_vld (item_vld),
        .item     (item)
    );

    pds_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .load  (load),
        .grp   (grp)
    );

    pds_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp      (grp),
        .load     (load),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the streaming percent decoder: queued text, scoreboard, idling phases.
module tb_top;
    import pds_pkg::*;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        pace_t      mode;
    } text_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       run_end;
        logic       str_end;
    } decoded_t;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 125;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    text_item_t pending[$];
    decoded_t decoded_q[$];
    logic in_fire = 1'b0;
    pace_t pace = PACE_FREE;
    int mismatches = 0;
    int cycle_cnt = 0;
    int src_idle_pct [4] = '{0, 74, 0, 12};
    int snk_stall_pct [4] = '{0, 0, 74, 12};

    logic [1:0] esc_phase = PH_IDLE;
    logic [7:0] esc_char = 8'h00;
    logic [7:0] run_buf [0:2];
    int run_len = 0;

    percent_decode_stream_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // bit 4 set for an upper-case hex digit, value in bits 3:0
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic void push_char(input logic [7:0] b);
        run_buf[run_len] = b;
        run_len++;
    endfunction

    function automatic void fresh_char(input logic [7:0] b);
        logic [7:0] u;
        logic [4:0] h;
        u = fold_case(b);
        h = hex_nibble(u);
        if (esc_phase == PH_IDLE)
        begin
            if (b == CHAR_PCT)
            begin
                esc_phase = PH_PCT;
            end
            else
            begin
                push_char(b);
            end
        end
        else
        begin
            esc_char = u;
            esc_phase = h[4] ? PH_HEX : PH_BAD;
        end
    endfunction

    function automatic void decode_item(input logic [7:0] b, input logic fin);
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] held;
        decoded_t d;
        run_len = 0;
        case (esc_phase)
            PH_IDLE, PH_PCT:
            begin
                fresh_char(b);
            end
            PH_HEX:
            begin
                hi = hex_nibble(esc_char);
                lo = hex_nibble(fold_case(b));
                if (lo[4])
                begin
                    push_char({hi[3:0], lo[3:0]});
                end
                else
                begin
                    push_char(CHAR_QMK);
                end
                esc_phase = PH_IDLE;
                esc_char = 8'h00;
            end
            default:
            begin
                held = esc_char;
                push_char(CHAR_PCT);
                esc_phase = PH_IDLE;
                esc_char = 8'h00;
                fresh_char(held);
                fresh_char(b);
            end
        endcase
        if (fin)
        begin
            esc_phase = PH_IDLE;
            esc_char = 8'h00;
        end
        for (int k = 0; k < run_len; k++)
        begin
            d.ch = run_buf[k];
            d.run_end = (k == run_len - 1);
            d.str_end = fin;
            decoded_q.push_back(d);
        end
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        if (mismatches < 100)
        begin
            $display("ERROR %s: got %02h, expected %02h", what, got, want);
        end
        mismatches++;
    endtask

    task automatic queue_byte(input logic [7:0] ch, input logic fin, input pace_t md);
        text_item_t t;
        t.ch = ch;
        t.fin = fin;
        t.mode = md;
        pending.push_back(t);
    endtask

    task automatic queue_text(input string txt, input logic fin);
        for (int i = 0; i < txt.len(); i++)
        begin
            queue_byte(txt[i], fin && (i == txt.len() - 1), PACE_FREE);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        decoded_t want;
        if (rst_n)
        begin
            in_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    report("unexpected item", m_tdata, 8'h00);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        report("out_byte", m_tdata, want.ch);
                    end
                    if (m_tlast !== want.run_end)
                    begin
                        report("run_last", {7'd0, m_tlast}, {7'd0, want.run_end});
                    end
                    if (m_tuser !== want.str_end)
                    begin
                        report("text_end", {7'd0, m_tuser}, {7'd0, want.str_end});
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_item(s_tdata, s_tlast);
            end
        end
    end

    always @(negedge clk)
    begin : driver
        text_item_t nxt;
        if (rst_n)
        begin
            if (!s_tvalid || in_fire)
            begin
                if (pending.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                end
                else if (pending[0].mode != pace && decoded_q.size() != 0)
                begin
                    // hold off until the previous phase has fully drained
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    pace = pending[0].mode;
                    if ($urandom_range(99) < src_idle_pct[pace])
                    begin
                        s_tvalid <= 1'b0;
                    end
                    else
                    begin
                        nxt = pending.pop_front();
                        s_tvalid <= 1'b1;
                        s_tdata <= nxt.ch;
                        s_tlast <= nxt.fin;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct[pace]);
        end
    end

    initial
    begin : stimulus
        int added;
        int len;
        int sel;
        int v;
        logic [7:0] ch;
        pace_t md;

        queue_byte(8'h01, 1'b0, PACE_FREE);
        queue_byte(8'hFF, 1'b0, PACE_FREE);
        queue_text("a%00%6a%fG%zx%%41", 1'b1);
        queue_text("%", 1'b1);
        queue_text("%4", 1'b1);
        queue_text("%g", 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            md = pace_t'(p);
            added = 0;
            while (added < ITEMS_PER_PHASE)
            begin
                len = $urandom_range(1, 10);
                for (int j = 0; j < len; j++)
                begin
                    sel = $urandom_range(99);
                    if (sel < 35)
                    begin
                        ch = CHAR_PCT;
                    end
                    else if (sel < 65)
                    begin
                        v = $urandom_range(15);
                        if (v < 10)
                        begin
                            ch = 8'(8'h30 + v);
                        end
                        else if ($urandom_range(1) == 1)
                        begin
                            ch = 8'(8'h61 + v - 10);
                        end
                        else
                        begin
                            ch = 8'(8'h41 + v - 10);
                        end
                    end
                    else
                    begin
                        ch = 8'($urandom_range(1, 255));
                    end
                    queue_byte(ch, (j == len - 1) && ($urandom_range(9) != 0), md);
                end
                added += len;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_tvalid || decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
